[hw/rtl/packet_serial_completeness_tracker_unit_macros.svh]
// assertion macros for the packet serial completeness tracker
// expects clk, and rst_n for PSCT_ASSERT, in the scope of each use
`ifndef PACKET_SERIAL_COMPLETENESS_TRACKER_UNIT_MACROS_SVH
`define PACKET_SERIAL_COMPLETENESS_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSCT_ASSERT(lbl, prop, msg)
`define PSCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/pstrk_pkg.sv]
// shared types and codes of the packet serial completeness tracker
// no dependencies
package pstrk_pkg;

  // request kinds carried on in_tuser
  localparam logic [1:0] REQ_PKT = 2'd0;
  localparam logic [1:0] REQ_QRY = 2'd1;
  localparam logic [1:0] REQ_CLR = 2'd2;

  localparam int WORD_W   = 64;
  localparam int OFF_W    = 6;
  localparam int TIME_W   = 64;
  localparam int SER_W    = 16;
  localparam int MISS_W   = 17;
  localparam int BRD_IN_W = 3;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ARR_RD, S_ARR_WR, S_Q_INIT, S_Q_RD, S_Q_ACC, S_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic cap;
    logic arr_rd;
    logic arr_wr;
    logic q_init;
    logic q_rd;
    logic q_acc;
    logic clr_start;
    logic clr_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_req;
    logic       brd_ok;
    logic       brd_en;
    logic       clr_last;
    logic       q_last;
    logic       out_busy;
  } sts_t;

endpackage

[hw/rtl/pstrk_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module pstrk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/pstrk_ctrl.sv]
// controller state machine of the completeness tracker
// depends on pstrk_pkg
module pstrk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  pstrk_pkg::sts_t sts,
  output pstrk_pkg::cmd_t cmd
);
  import pstrk_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = (state_r == S_IDLE) && sts.in_valid;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (sts.in_req)
            REQ_PKT: state_nxt = (sts.brd_ok && sts.brd_en) ? S_ARR_RD : S_DONE;
            REQ_QRY: state_nxt = sts.brd_ok ? S_Q_INIT : S_DONE;
            REQ_CLR: state_nxt = S_CLR;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ARR_RD: state_nxt = S_ARR_WR;
      S_ARR_WR: state_nxt = S_DONE;
      S_Q_INIT: state_nxt = S_Q_RD;
      S_Q_RD:   state_nxt = S_Q_ACC;
      S_Q_ACC:  state_nxt = sts.q_last ? S_DONE : S_Q_RD;
      S_CLR:    if (sts.clr_last) state_nxt = S_DONE;
      S_DONE:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      S_INIT: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.cap       = accept;
        cmd.clr_start = accept && (sts.in_req == REQ_CLR);
      end
      S_ARR_RD: cmd.arr_rd   = 1'b1;
      S_ARR_WR: cmd.arr_wr   = 1'b1;
      S_Q_INIT: cmd.q_init   = 1'b1;
      S_Q_RD:   cmd.q_rd     = 1'b1;
      S_Q_ACC:  cmd.q_acc    = 1'b1;
      S_CLR:    cmd.clr_step = 1'b1;
      S_DONE:   cmd.res_load = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end
endmodule

[hw/rtl/pstrk_dp.sv]
// datapath of the completeness tracker: received map, per-board registers, result register
// depends on pstrk_pkg, pstrk_ram and the assertion macro header
`include "packet_serial_completeness_tracker_unit_macros.svh"
module pstrk_dp #(
  parameter int NUM_BOARDS   = 8,
  parameter int SERIAL_SPACE = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pstrk_pkg::cmd_t               cmd,
  output pstrk_pkg::sts_t               sts,
  input  logic                          in_valid,
  input  logic [1:0]                    in_req,
  input  logic [pstrk_pkg::BRD_IN_W-1:0] in_board,
  input  logic [pstrk_pkg::SER_W-1:0]   in_serial,
  input  logic [1:0]                    in_admin,
  input  logic [pstrk_pkg::TIME_W-1:0]  in_time,
  input  logic [7:0]                    cfg_mask,
  input  logic                          cfg_we,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_acc,
  output logic                          out_cmp,
  output logic                          out_start,
  output logic                          out_stop,
  output logic [pstrk_pkg::SER_W-1:0]   out_lo,
  output logic [pstrk_pkg::SER_W-1:0]   out_hi,
  output logic [pstrk_pkg::MISS_W-1:0]  out_miss
);
  import pstrk_pkg::*;

  localparam int BW    = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
  localparam int SW    = $clog2(SERIAL_SPACE);
  localparam int WPB   = SERIAL_SPACE / WORD_W;
  localparam int DEPTH = NUM_BOARDS * WPB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // captured request
  logic [BW-1:0]     brd_r;
  logic [SW-1:0]     ser_r;
  logic [1:0]        adm_r;
  logic [TIME_W-1:0] time_r;
  logic [7:0]        mask_cfg_r;

  // per-board state
  logic [SW-1:0]     start_ser_r [NUM_BOARDS];
  logic [SW-1:0]     stop_ser_r  [NUM_BOARDS];
  logic [SW-1:0]     early_ser_r [NUM_BOARDS];
  logic [SW-1:0]     late_ser_r  [NUM_BOARDS];
  logic [TIME_W-1:0] early_t_r   [NUM_BOARDS];
  logic [TIME_W-1:0] late_t_r    [NUM_BOARDS];
  logic [NUM_BOARDS-1:0] start_seen_r, stop_seen_r, early_v_r, late_v_r;

  // query walk
  logic [SW-1:0]     s_r, lo_r, hi_r;
  logic [SW:0]       rem_r;
  logic [6:0]        n_r, n_nxt, avail;
  logic [WORD_W-1:0] wmask_r, wmask_nxt, lowm;
  logic [MISS_W-1:0] miss_r;
  logic              qv_r, qstart_r, qstop_r, acc_r;
  logic [SW-1:0]     lo_sel, hi_sel, span;
  logic [6:0]        pop;

  // clearing sweep
  logic [AW-1:0]     clr_cnt_r;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, word_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [BW-1:0]     in_brd;

  logic out_valid_r, out_acc_r, out_cmp_r, out_start_r, out_stop_r;
  logic [SER_W-1:0]  out_lo_r, out_hi_r;
  logic [MISS_W-1:0] out_miss_r;

  function automatic logic [6:0] popcnt(input logic [WORD_W-1:0] v);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + 7'(v[i]);
    end
    return c;
  endfunction

  assign in_brd = BW'(in_board);

  // status toward the controller
  always_comb begin
    sts.in_valid = in_valid;
    sts.in_req   = in_req;
    sts.brd_ok   = (32'(in_board) < NUM_BOARDS);
    sts.brd_en   = mask_cfg_r[in_board];
    sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
    sts.q_last   = (rem_r == (SW+1)'(n_r));
    sts.out_busy = out_valid_r && !out_ready;
  end

  // enable mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_cfg_r <= '0;
    end else if (cfg_we) begin
      mask_cfg_r <= cfg_mask;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      brd_r  <= in_brd;
      ser_r  <= SW'(in_serial);
      adm_r  <= in_admin;
      time_r <= in_time;
    end
  end

  // word address of the current board and serial
  assign word_addr = AW'(AW'(brd_r) * AW'(WPB)
                   + AW'((cmd.arr_rd || cmd.arr_wr) ? ser_r[SW-1:OFF_W] : s_r[SW-1:OFF_W]));

  // memory port selection
  always_comb begin
    ram_raddr = word_addr;
    ram_waddr = word_addr;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | (WORD_W'(1) << ser_r[OFF_W-1:0]);
    if (cmd.clr_step) begin
      ram_waddr = clr_cnt_r;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd.arr_wr) begin
      ram_we = 1'b1;
    end
  end

  pstrk_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // per-board flags and serial registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seen_r <= '0;
      stop_seen_r  <= '0;
      early_v_r    <= '0;
      late_v_r     <= '0;
      for (int b = 0; b < NUM_BOARDS; b++) begin
        start_ser_r[b] <= '0;
        stop_ser_r[b]  <= '0;
        early_ser_r[b] <= '0;
        late_ser_r[b]  <= '0;
        early_t_r[b]   <= '0;
        late_t_r[b]    <= '0;
      end
    end else if (cmd.clr_start) begin
      start_seen_r <= '0;
      stop_seen_r  <= '0;
      early_v_r    <= '0;
      late_v_r     <= '0;
    end else if (cmd.arr_wr) begin
      if (adm_r[0]) begin
        start_ser_r[brd_r]  <= ser_r;
        start_seen_r[brd_r] <= 1'b1;
      end
      if (adm_r[1]) begin
        stop_ser_r[brd_r]  <= ser_r;
        stop_seen_r[brd_r] <= 1'b1;
      end
      if (!early_v_r[brd_r] || (time_r < early_t_r[brd_r])) begin
        early_ser_r[brd_r] <= ser_r;
        early_t_r[brd_r]   <= time_r;
        early_v_r[brd_r]   <= 1'b1;
      end
      if (!late_v_r[brd_r] || (time_r > late_t_r[brd_r])) begin
        late_ser_r[brd_r] <= ser_r;
        late_t_r[brd_r]   <= time_r;
        late_v_r[brd_r]   <= 1'b1;
      end
    end
  end

  // query range and chunk selection
  always_comb begin
    lo_sel    = start_seen_r[brd_r] ? start_ser_r[brd_r] : early_ser_r[brd_r];
    hi_sel    = stop_seen_r[brd_r] ? stop_ser_r[brd_r] : late_ser_r[brd_r];
    span      = hi_sel - lo_sel;
    avail     = 7'(WORD_W) - 7'(s_r[OFF_W-1:0]);
    n_nxt     = (rem_r < (SW+1)'(avail)) ? 7'(rem_r) : avail;
    lowm      = n_nxt[6] ? '1 : ((WORD_W'(1) << n_nxt[5:0]) - WORD_W'(1));
    wmask_nxt = lowm << s_r[OFF_W-1:0];
    pop       = popcnt(~ram_rdata & wmask_r);
  end

  // query walk registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      qv_r     <= 1'b0;
      acc_r    <= 1'b0;
      qstart_r <= 1'b0;
      qstop_r  <= 1'b0;
      lo_r     <= '0;
      hi_r     <= '0;
      miss_r   <= '0;
    end else if (cmd.arr_wr) begin
      acc_r <= 1'b1;
    end else if (cmd.q_init) begin
      qv_r     <= 1'b1;
      qstart_r <= start_seen_r[brd_r];
      qstop_r  <= stop_seen_r[brd_r];
      lo_r     <= lo_sel;
      hi_r     <= hi_sel;
      s_r      <= lo_sel;
      rem_r    <= {1'b0, span} + (SW+1)'(1);
    end else if (cmd.q_rd) begin
      n_r     <= n_nxt;
      wmask_r <= wmask_nxt;
    end else if (cmd.q_acc) begin
      miss_r <= miss_r + MISS_W'(pop);
      s_r    <= s_r + SW'(n_r);
      rem_r  <= rem_r - (SW+1)'(n_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_acc_r   <= acc_r;
      out_cmp_r   <= qv_r && qstop_r && (miss_r == '0);
      out_start_r <= qstart_r;
      out_stop_r  <= qstop_r;
      out_lo_r    <= SER_W'(lo_r);
      out_hi_r    <= SER_W'(hi_r);
      out_miss_r  <= miss_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_acc   = out_acc_r;
  assign out_cmp   = out_cmp_r;
  assign out_start = out_start_r;
  assign out_stop  = out_stop_r;
  assign out_lo    = out_lo_r;
  assign out_hi    = out_hi_r;
  assign out_miss  = out_miss_r;

  `PSCT_ASSERT(a_load_free, cmd.res_load |-> (!out_valid_r || out_ready), "result overwritten")
  `PSCT_ASSERT(a_arr_quiet, (out_valid_r && out_acc_r) |-> (!out_cmp_r && out_miss_r == '0 && !out_stop_r), "arrival result carries query fields")
  `PSCT_ASSERT(a_cmp_clean, (out_valid_r && out_cmp_r) |-> (out_stop_r && out_miss_r == '0), "complete without stop or with gaps")
endmodule

[hw/rtl/packet_serial_completeness_tracker_unit.sv]
// Packet serial completeness tracker. One transaction in gives one transaction out.
// A packet arrival does a read-modify-write of one 64-bit map word.
// A query walks its serial range one map word at a time, reading each word and then
// accumulating its missing count. A clear, and the pass after reset, writes zero
// to every one of the NUM_BOARDS*SERIAL_SPACE/64 map words (8192 by default), one a
// cycle; no input is taken during that pass.
// depends on pstrk_pkg, pstrk_ctrl, pstrk_dp
module packet_serial_completeness_tracker_unit #(
  parameter int NUM_BOARDS   = 8,
  parameter int SERIAL_SPACE = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // board_id[2:0], serial_no[18:3], admin_flags[20:19], arrival_time_us[84:21]
  input  logic [87:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // packet_accepted[0], run_complete[1], start_was_seen[2], stop_was_seen[3],
  // range_start[19:4], range_stop[35:20], missing_count[52:36]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import pstrk_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic acc, cmp, st, sp;
  logic [SER_W-1:0]  lo, hi;
  logic [MISS_W-1:0] miss;

  pstrk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pstrk_dp #(.NUM_BOARDS(NUM_BOARDS), .SERIAL_SPACE(SERIAL_SPACE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_board  (in_tdata[2:0]),
    .in_serial (in_tdata[18:3]),
    .in_admin  (in_tdata[20:19]),
    .in_time   (in_tdata[84:21]),
    .cfg_mask  (cfg_wdata),
    .cfg_we    (cfg_we),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_acc   (acc),
    .out_cmp   (cmp),
    .out_start (st),
    .out_stop  (sp),
    .out_lo    (lo),
    .out_hi    (hi),
    .out_miss  (miss)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = {3'b000, miss, hi, lo, sp, st, cmp, acc};
endmodule

[test/packet_serial_completeness_tracker_unit_tb.sv]
// self-checking testbench for the packet serial completeness tracker
// depends on pstrk_pkg and packet_serial_completeness_tracker_unit
`timescale 1ns / 100ps

module packet_serial_completeness_tracker_unit_tb;
  import pstrk_pkg::*;

  localparam int NB = 8;
  localparam int WATCH_LIMIT = 60000;

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  board;
    logic [15:0] serial;
    logic [1:0]  admin;
    logic [63:0] stamp;
  } pkt_txn_t;

  typedef struct {
    logic        accepted;
    logic        complete;
    logic        start_seen;
    logic        stop_seen;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [16:0] missing;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  pkt_txn_t pending_txns[$];
  verdict_t verdict_q[$];
  bit       fails;
  bit       no_idle;
  int       in_gap;
  int       out_gap;
  int       quiet_cycles;

  // shadow of the tracker state
  bit          seen_map [0:NB-1][0:65535];
  logic [15:0] start_ser [NB];
  logic [15:0] stop_ser [NB];
  bit          start_flag [NB];
  bit          stop_flag [NB];
  logic [15:0] first_ser [NB];
  logic [63:0] first_t [NB];
  bit          first_ok [NB];
  logic [15:0] last_ser [NB];
  logic [63:0] last_t [NB];
  bit          last_ok [NB];
  logic [7:0]  enable_mask;

  // stimulus generator state per board
  logic [15:0] next_ser [NB];
  logic [63:0] next_t [NB];
  bit          start_sent [NB];

  packet_serial_completeness_tracker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // wipe maps and flags of every board
  task automatic wipe_boards();
    for (int b = 0; b < NB; b++) begin
      for (int s = 0; s < 65536; s++) seen_map[b][s] = 0;
      start_flag[b] = 0;
      stop_flag[b] = 0;
      first_ok[b] = 0;
      last_ok[b] = 0;
    end
  endtask

  // expected result of one transaction, updating the shadow state
  task automatic track_txn(input pkt_txn_t t, output verdict_t v);
    int b;
    logic [15:0] span;
    logic [15:0] s;
    int miss;
    b = t.board;
    v = '{default: '0};
    case (t.req)
      REQ_PKT: begin
        if (enable_mask[b]) begin
          seen_map[b][t.serial] = 1;
          if (t.admin[0]) begin start_ser[b] = t.serial; start_flag[b] = 1; end
          if (t.admin[1]) begin stop_ser[b] = t.serial; stop_flag[b] = 1; end
          if (!first_ok[b] || t.stamp < first_t[b]) begin
            first_ser[b] = t.serial; first_t[b] = t.stamp; first_ok[b] = 1;
          end
          if (!last_ok[b] || t.stamp > last_t[b]) begin
            last_ser[b] = t.serial; last_t[b] = t.stamp; last_ok[b] = 1;
          end
          v.accepted = 1;
        end
      end
      REQ_QRY: begin
        v.lo = start_flag[b] ? start_ser[b] : first_ser[b];
        v.hi = stop_flag[b] ? stop_ser[b] : last_ser[b];
        span = v.hi - v.lo;
        miss = 0;
        for (int j = 0; j <= int'(span); j++) begin
          s = v.lo + 16'(j);
          if (!seen_map[b][s]) miss++;
        end
        v.missing = 17'(miss);
        v.complete = stop_flag[b] && miss == 0;
        v.start_seen = start_flag[b];
        v.stop_seen = stop_flag[b];
      end
      REQ_CLR: wipe_boards();
      default: ;
    endcase
  endtask

  // driver: feeds queued transactions, random gaps after acceptance
  always @(posedge clk) begin
    pkt_txn_t cur;
    verdict_t v;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        cur = pending_txns.pop_front();
        track_txn(cur, v);
        verdict_q.push_back(v);
        if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transaction
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (pending_txns.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= {3'b000, pending_txns[0].stamp, pending_txns[0].admin,
                     pending_txns[0].serial, pending_txns[0].board};
        in_tuser <= pending_txns[0].req;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // monitor: random back-pressure and field compare
  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      out_tready <= 0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fails = 1;
        end else begin
          e = verdict_q.pop_front();
          if (out_tdata[0] !== e.accepted || out_tdata[1] !== e.complete ||
              out_tdata[2] !== e.start_seen || out_tdata[3] !== e.stop_seen ||
              out_tdata[19:4] !== e.lo || out_tdata[35:20] !== e.hi ||
              out_tdata[52:36] !== e.missing || out_tdata[55:53] !== 3'b000) begin
            $display("%0t: mismatch expected acc=%b cpl=%b st=%b sp=%b lo=%h hi=%h miss=%0d",
                     $time, e.accepted, e.complete, e.start_seen, e.stop_seen,
                     e.lo, e.hi, e.missing);
            $display("%0t:          actual acc=%b cpl=%b st=%b sp=%b lo=%h hi=%h miss=%0d",
                     $time, out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3],
                     out_tdata[19:4], out_tdata[35:20], out_tdata[52:36]);
            fails = 1;
          end
        end
        if (!no_idle && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 10);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_txn(input logic [1:0] req, input logic [2:0] board,
                          input logic [15:0] serial, input logic [1:0] admin,
                          input logic [63:0] stamp);
    pkt_txn_t t;
    t.req = req; t.board = board; t.serial = serial; t.admin = admin; t.stamp = stamp;
    pending_txns.push_back(t);
  endtask

  // fresh serial window for a board, sometimes straddling the wrap point
  task automatic reseed_board(input int b);
    next_ser[b] = ($urandom_range(0, 4) == 0) ? 16'(16'hfff0 + $urandom_range(0, 12))
                                              : 16'($urandom);
    next_t[b] = {$urandom, $urandom};
    start_sent[b] = 0;
  endtask

  // mostly in-order packet streams with start/stop markers, plus noise
  task automatic gen_random(input int n);
    int b;
    int r;
    logic [1:0] adm;
    logic [15:0] ser;
    logic [63:0] ts;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 199);
      b = $urandom_range(0, NB - 1);
      if (r < 2) begin
        push_txn(REQ_CLR, 3'(b), 16'($urandom), 2'($urandom), {$urandom, $urandom});
        for (int k = 0; k < NB; k++) reseed_board(k);
      end else if (r < 5) begin
        push_txn(2'd3, 3'(b), 16'($urandom), 2'($urandom), {$urandom, $urandom});
      end else if (r < 45) begin
        push_txn(REQ_QRY, 3'(b), 16'($urandom), 2'($urandom), {$urandom, $urandom});
      end else begin
        adm = 2'b00;
        if (!start_sent[b] && $urandom_range(0, 3) == 0) begin
          adm[0] = 1;
          start_sent[b] = 1;
        end
        if ($urandom_range(0, 15) == 0) adm[1] = 1;
        r = $urandom_range(0, 99);
        if (r < 3) ser = next_ser[b] - 16'($urandom_range(1, 3));
        else if (r < 5) ser = next_ser[b] + 16'($urandom_range(1, 3));
        else ser = next_ser[b];
        if (r >= 3) next_ser[b] = ser + 16'($urandom_range(1, 2));
        ts = next_t[b] + 64'($urandom_range(0, 3));
        next_t[b] += 8;
        if ($urandom_range(0, 49) == 0) ts = {$urandom, $urandom};
        push_txn(REQ_PKT, 3'(b), ser, adm, ts);
      end
    end
  endtask

  task automatic write_mask(input logic [7:0] m);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
    enable_mask = m;
  endtask

  task automatic drain();
    while (pending_txns.size() > 0 || verdict_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    fails = 0;
    no_idle = 0;
    quiet_cycles = 0;
    enable_mask = 0;
    wipe_boards();
    for (int b = 0; b < NB; b++) begin
      start_ser[b] = 0; stop_ser[b] = 0; first_ser[b] = 0; last_ser[b] = 0;
      first_t[b] = 0; last_t[b] = 0;
      reseed_board(b);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: nothing enabled, then all boards
    write_mask(8'h00);
    @(negedge clk);
    push_txn(REQ_PKT, 3'd0, 16'h0005, 2'b01, 64'd1);
    push_txn(REQ_QRY, 3'd2, 16'h0000, 2'b00, 64'd0);
    drain();
    write_mask(8'hff);
    @(negedge clk);
    // start 0000 and stop ffff walk the whole space; board 3 has start above stop, forcing a walk across the wrap
    push_txn(REQ_PKT, 3'd0, 16'h0000, 2'b01, 64'd5);
    push_txn(REQ_PKT, 3'd0, 16'hffff, 2'b10, 64'hffff_ffff_ffff_ffff);
    push_txn(REQ_PKT, 3'd0, 16'h0001, 2'b00, 64'd0);
    push_txn(REQ_QRY, 3'd0, 16'h0000, 2'b00, 64'd0);
    push_txn(REQ_PKT, 3'd3, 16'h000a, 2'b01, 64'd9);
    push_txn(REQ_PKT, 3'd3, 16'h0005, 2'b10, 64'd10);
    push_txn(REQ_QRY, 3'd3, 16'h0000, 2'b00, 64'd0);
    // equal timestamps keep the first arrival on both ends
    push_txn(REQ_PKT, 3'd1, 16'd100, 2'b00, 64'd50);
    push_txn(REQ_PKT, 3'd1, 16'd101, 2'b00, 64'd50);
    push_txn(REQ_QRY, 3'd1, 16'h0000, 2'b00, 64'd0);
    push_txn(REQ_PKT, 3'd1, 16'd99, 2'b00, 64'd49);
    push_txn(REQ_PKT, 3'd1, 16'd102, 2'b00, 64'd51);
    push_txn(REQ_QRY, 3'd1, 16'h0000, 2'b00, 64'd0);
    // start and stop in one packet
    push_txn(REQ_PKT, 3'd7, 16'h1234, 2'b11, 64'h8000_0000_0000_0000);
    push_txn(REQ_QRY, 3'd7, 16'h0000, 2'b00, 64'd0);
    push_txn(REQ_QRY, 3'd6, 16'hffff, 2'b11, 64'hffff_ffff_ffff_ffff);
    push_txn(2'd3, 3'd7, 16'hffff, 2'b11, 64'hffff_ffff_ffff_ffff);
    // after a clear, queries fall back to the stale serials
    push_txn(REQ_CLR, 3'd0, 16'h0000, 2'b00, 64'd0);
    push_txn(REQ_QRY, 3'd1, 16'h0000, 2'b00, 64'd0);
    push_txn(REQ_QRY, 3'd7, 16'h0000, 2'b00, 64'd0);
    drain();

    // disabled boards are ignored on arrival but still answer queries
    write_mask(8'h55);
    @(negedge clk);
    push_txn(REQ_PKT, 3'd1, 16'd200, 2'b11, 64'd3);
    push_txn(REQ_QRY, 3'd1, 16'h0000, 2'b00, 64'd0);
    gen_random(350);
    drain();
    write_mask(8'haa);
    @(negedge clk);
    gen_random(350);
    drain();
    write_mask(8'($urandom));
    @(negedge clk);
    gen_random(350);
    drain();
    write_mask(8'hff);
    @(negedge clk);
    gen_random(400);
    drain();
    no_idle = 1;
    @(negedge clk);
    gen_random(350);
    drain();
    repeat (50) @(posedge clk);

    if (!fails) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pstrk_pkg.sv
hw/rtl/pstrk_ram.sv
hw/rtl/pstrk_ctrl.sv
hw/rtl/pstrk_dp.sv
hw/rtl/packet_serial_completeness_tracker_unit.sv
test/packet_serial_completeness_tracker_unit_tb.sv
